### src/kic_pkg.sv
// Shared types and constants of the keypad integer calculator.
package kic_pkg;

  localparam int unsigned KeyWidth   = 3;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned OpWidth    = 3;
  localparam int unsigned DispWidth  = 32;

  localparam logic [DigitWidth-1:0] DigitMax = DigitWidth'(9);

  typedef enum logic [KeyWidth-1:0] {
    KEY_DIGIT  = 3'd0,
    KEY_PLUS   = 3'd1,
    KEY_MINUS  = 3'd2,
    KEY_MUL    = 3'd3,
    KEY_DIV    = 3'd4,
    KEY_EQUALS = 3'd5,
    KEY_SQUARE = 3'd6
  } key_e;

  typedef enum logic [OpWidth-1:0] {
    OP_NONE  = 3'd0,
    OP_PLUS  = 3'd1,
    OP_MINUS = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4
  } op_e;

  typedef struct packed {
    logic [KeyWidth-1:0]   key_opcode;
    logic [DigitWidth-1:0] digit_value;
  } kic_in_t;

  typedef struct packed {
    logic signed [DispWidth-1:0] display_value;
    logic [OpWidth-1:0]          pending_operation;
    logic                        divide_by_zero;
  } kic_out_t;

  typedef struct packed {
    logic start;
    op_e  op;
  } kic_unit_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } kic_unit_rsp_t;

endpackage

### src/keypad_integer_calculator_core.sv
// Keypad integer calculator: key sequencer, calculator state and result register.
//
// Usage: one key per request on the input channel (in_valid_i / in_stall_o,
// payload in_req_i), one result per key on the output channel (out_valid_o /
// out_stall_i, payload out_req_o). A request moves on a rising edge with valid
// high and stall low.
// One key at a time: in_stall_o stays high from acceptance until the result is
// loaded into the output register.
// Path from acceptance to the push state, W = VALUE_WIDTH:
//   digit, ignored key, operator or equals with nothing pending: straight to push;
//   completing a pending operation: waits in ST_FIN for the unit's done pulse;
//   add, subtract and division by zero finish without the W-step loops;
//   square: waits in ST_SQR, after ST_FIN when an operation pends.
// Add, subtract and the loop steps share one adder in kic_unit; the W-step
// shift-add multiply and restoring divide loops set the worst case.
// Reset clears the display, left operand, pending operation and new-number
// flag, and empties the output register.
// While the receiver stalls, the result waits in the output register; a
// further key may be accepted and worked on, and its result is held back
// until the register drains.
module keypad_integer_calculator_core import kic_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  kic_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output kic_out_t out_req_o
);

  localparam int unsigned ExtWidth = (VALUE_WIDTH > DispWidth) ? VALUE_WIDTH : DispWidth;
  localparam logic [VALUE_WIDTH+3:0] LimNeg = {4'b0000, 1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH+3:0] LimPos = {4'b0000, 1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FIN  = 4'b0010,
    ST_SQR  = 4'b0100,
    ST_PUSH = 4'b1000
  } state_e;

  function automatic op_e op_of_key(input key_e key);
    op_e op;
    unique case (key)
      KEY_PLUS:  op = OP_PLUS;
      KEY_MINUS: op = OP_MINUS;
      KEY_MUL:   op = OP_MUL;
      KEY_DIV:   op = OP_DIV;
      default:   op = OP_NONE;
    endcase
    return op;
  endfunction

  state_e                 state_q, state_d;
  logic [VALUE_WIDTH-1:0] disp_q, disp_d;
  logic [VALUE_WIDTH-1:0] left_q, left_d;
  op_e                    latch_q, latch_d;
  logic                   start_q, start_d;
  logic                   dz_q, dz_d;
  key_e                   key_q, key_d;
  logic                   out_valid_q;
  kic_out_t               out_q;

  kic_unit_req_t          ureq;
  kic_unit_rsp_t          ursp;
  logic [VALUE_WIDTH-1:0] ua, ub, ures;

  logic [VALUE_WIDTH-1:0] dig_base, dig_mag, dig_new;
  logic [VALUE_WIDTH+3:0] dig_prod;
  logic                   dig_neg, dig_ok;
  key_e                   in_key;
  logic                   push;
  logic [ExtWidth-1:0]    disp_ext;

  kic_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ureq),
    .a_i   (ua),
    .b_i   (ub),
    .rsp_o (ursp),
    .res_o (ures)
  );

  assign in_key   = key_e'(in_req_i.key_opcode);
  assign dig_base = start_q ? '0 : disp_q;
  assign dig_neg  = dig_base[VALUE_WIDTH-1];
  assign dig_mag  = dig_neg ? ('0 - dig_base) : dig_base;
  assign dig_prod = (VALUE_WIDTH+4)'({dig_mag, 3'b000}) + (VALUE_WIDTH+4)'({dig_mag, 1'b0})
                  + (VALUE_WIDTH+4)'(in_req_i.digit_value);
  assign dig_ok   = dig_neg ? (dig_prod <= LimNeg) : (dig_prod <= LimPos);
  assign dig_new  = dig_neg ? ('0 - dig_prod[VALUE_WIDTH-1:0]) : dig_prod[VALUE_WIDTH-1:0];

  assign push = (state_q == ST_PUSH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    disp_d     = disp_q;
    left_d     = left_q;
    latch_d    = latch_q;
    start_d    = start_q;
    dz_d       = dz_q;
    key_d      = key_q;
    ureq.start = 1'b0;
    ureq.op    = OP_NONE;
    ua         = left_q;
    ub         = disp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = in_key;
          dz_d    = 1'b0;
          state_d = ST_PUSH;
          unique case (in_key)
            KEY_DIGIT: begin
              if (in_req_i.digit_value <= DigitMax) begin
                start_d = 1'b0;
                if (dig_ok) begin
                  disp_d = dig_new;
                end
              end
            end
            KEY_PLUS, KEY_MINUS, KEY_MUL, KEY_DIV: begin
              if (latch_q != OP_NONE) begin
                ureq.start = 1'b1;
                ureq.op    = latch_q;
                state_d    = ST_FIN;
              end else begin
                latch_d = op_of_key(in_key);
                start_d = 1'b1;
                left_d  = disp_q;
              end
            end
            KEY_EQUALS: begin
              if (latch_q != OP_NONE) begin
                ureq.start = 1'b1;
                ureq.op    = latch_q;
                state_d    = ST_FIN;
              end
            end
            KEY_SQUARE: begin
              ureq.start = 1'b1;
              if (latch_q != OP_NONE) begin
                ureq.op = latch_q;
                state_d = ST_FIN;
              end else begin
                ureq.op = OP_MUL;
                ua      = disp_q;
                state_d = ST_SQR;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIN: begin
        if (ursp.done) begin
          disp_d  = ures;
          dz_d    = ursp.div_zero;
          latch_d = OP_NONE;
          start_d = 1'b1;
          state_d = ST_PUSH;
          unique case (key_q)
            KEY_SQUARE: begin
              ureq.start = 1'b1;
              ureq.op    = OP_MUL;
              ua         = ures;
              ub         = ures;
              state_d    = ST_SQR;
            end
            KEY_EQUALS: ;
            default: begin
              latch_d = op_of_key(key_q);
              left_d  = ures;
            end
          endcase
        end
      end
      ST_SQR: begin
        if (ursp.done) begin
          disp_d  = ures;
          left_d  = ures;
          latch_d = OP_NONE;
          start_d = 1'b1;
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      disp_q  <= '0;
      left_q  <= '0;
      latch_q <= OP_NONE;
      start_q <= 1'b0;
      dz_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      disp_q  <= disp_d;
      left_q  <= left_d;
      latch_q <= latch_d;
      start_q <= start_d;
      dz_q    <= dz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign disp_ext = ExtWidth'($signed(disp_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q.display_value     <= $signed(disp_ext[DispWidth-1:0]);
      out_q.pending_operation <= latch_q;
      out_q.divide_by_zero    <= dz_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("key taken without going busy");

  a_square_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQR) |-> (latch_q == OP_NONE)) else $error("operation pends during square");

  a_push_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (out_valid_q && state_q == ST_IDLE)) else $error("result not loaded");

endmodule

### src/kic_unit.sv
// Shared iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide.
module kic_unit import kic_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kic_unit_req_t          req_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  output kic_unit_rsp_t          rsp_o,
  output logic [VALUE_WIDTH-1:0] res_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH + 1);

  op_e                   op_q, op_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  dz_q, dz_d;
  logic                  neg_q, neg_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [VALUE_WIDTH-1:0] a_q, a_d;
  logic [VALUE_WIDTH-1:0] b_q, b_d;

  logic [VALUE_WIDTH:0]   add_x, add_y;
  logic                   add_cin;
  logic [VALUE_WIDTH+1:0] sum;

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    if (req_i.start) begin
      unique case (req_i.op)
        OP_PLUS: begin
          add_x = {1'b0, a_i};
          add_y = {1'b0, b_i};
        end
        OP_MINUS: begin
          add_x   = {1'b0, a_i};
          add_y   = ~{1'b0, b_i};
          add_cin = 1'b1;
        end
        default: ;
      endcase
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        if (op_q == OP_DIV) begin
          add_x   = {acc_q, a_q[VALUE_WIDTH-1]};
          add_y   = ~{1'b0, b_q};
          add_cin = 1'b1;
        end else begin
          add_x = {1'b0, acc_q};
          add_y = b_q[0] ? {1'b0, a_q} : '0;
        end
      end else if (op_q == OP_DIV) begin
        add_y   = ~{1'b0, a_q};
        add_cin = 1'b1;
      end
    end
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + {{(VALUE_WIDTH+1){1'b0}}, add_cin};

  always_comb begin
    op_d   = op_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dz_d   = dz_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (req_i.start) begin
      op_d = req_i.op;
      dz_d = 1'b0;
      unique case (req_i.op)
        OP_PLUS, OP_MINUS: begin
          acc_d  = sum[VALUE_WIDTH-1:0];
          done_d = 1'b1;
        end
        OP_MUL: begin
          acc_d  = '0;
          a_d    = a_i;
          b_d    = b_i;
          cnt_d  = CntWidth'(VALUE_WIDTH);
          busy_d = 1'b1;
        end
        OP_DIV: begin
          acc_d = '0;
          if (b_i == '0) begin
            dz_d   = 1'b1;
            done_d = 1'b1;
          end else begin
            a_d    = a_i[VALUE_WIDTH-1] ? ('0 - a_i) : a_i;
            b_d    = b_i[VALUE_WIDTH-1] ? ('0 - b_i) : b_i;
            neg_d  = a_i[VALUE_WIDTH-1] ^ b_i[VALUE_WIDTH-1];
            cnt_d  = CntWidth'(VALUE_WIDTH);
            busy_d = 1'b1;
          end
        end
        default: begin
          done_d = 1'b1;
        end
      endcase
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CntWidth'(1);
        if (op_q == OP_DIV) begin
          if (sum[VALUE_WIDTH+1]) begin
            acc_d = sum[VALUE_WIDTH-1:0];
            a_d   = {a_q[VALUE_WIDTH-2:0], 1'b1};
          end else begin
            acc_d = {acc_q[VALUE_WIDTH-2:0], a_q[VALUE_WIDTH-1]};
            a_d   = {a_q[VALUE_WIDTH-2:0], 1'b0};
          end
        end else begin
          acc_d = sum[VALUE_WIDTH-1:0];
          a_d   = {a_q[VALUE_WIDTH-2:0], 1'b0};
          b_d   = {1'b0, b_q[VALUE_WIDTH-1:1]};
        end
      end else begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (op_q == OP_DIV) begin
          acc_d = neg_q ? sum[VALUE_WIDTH-1:0] : a_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dz_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      dz_q   <= dz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.div_zero = dz_q;
  assign res_o          = acc_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("unit started while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("unit done held longer than one cycle");

  a_dz_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dz_q |-> op_q == OP_DIV) else $error("divide by zero flagged outside a division");

  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.start && req_i.op == OP_MUL) |=> busy_q) else $error("multiply did not start");

endmodule
